[rtl/rac_pkg.sv]
package rac_pkg;

  localparam int MODE_W = 2;
  localparam int ID_W   = 7;
  localparam int REG_W  = 3;
  localparam int KIND_W = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_NEED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REL1   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RELALL = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] K_STORE  = 3'd0;
  localparam logic [KIND_W-1:0] K_LOAD   = 3'd1;
  localparam logic [KIND_W-1:0] K_GRANT  = 3'd2;
  localparam logic [KIND_W-1:0] K_REJECT = 3'd3;
  localparam logic [KIND_W-1:0] K_DONE   = 3'd4;

  // register pointer sources
  localparam logic [2:0] PS_HIT    = 3'd0;
  localparam logic [2:0] PS_FREE   = 3'd1;
  localparam logic [2:0] PS_VICTIM = 3'd2;
  localparam logic [2:0] PS_SEL    = 3'd3;
  localparam logic [2:0] PS_ZERO   = 3'd4;

  // result register field sources
  localparam logic [1:0] RS_PTR  = 2'd0;
  localparam logic [1:0] RS_SEL  = 2'd1;
  localparam logic [1:0] RS_ZERO = 2'd2;

  // result id field sources
  localparam logic [1:0] IS_REQ   = 2'd0;
  localparam logic [1:0] IS_OWNER = 2'd1;
  localparam logic [1:0] IS_ZERO  = 2'd2;

  typedef struct packed {
    logic              cap;
    logic              look;
    logic              ptr_set;
    logic [2:0]        ptr_src;
    logic              ptr_inc;
    logic              spill;
    logic              vadv;
    logic              alloc;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic [1:0]        emit_reg_src;
    logic [1:0]        emit_id_src;
    logic              emit_last;
  } rac_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              id_ok;
    logic              rs_ok;
    logic              hit;
    logic              free_any;
    logic              sel_valid;
    logic              ptr_valid;
    logic              ptr_last;
    logic              spilled;
    logic              out_free;
    logic              clr_done;
  } rac_sts_t;

endpackage

[rtl/rac_if.sv]
interface rac_in_if;
  logic                        valid;
  logic                        ready;
  logic [rac_pkg::MODE_W-1:0]  mode;
  logic [rac_pkg::ID_W-1:0]    var_id;
  logic [rac_pkg::REG_W-1:0]   reg_sel;

  modport source (output valid, output mode, output var_id, output reg_sel, input ready);
  modport sink   (input valid, input mode, input var_id, input reg_sel, output ready);
endinterface

interface rac_out_if;
  logic                        valid;
  logic                        ready;
  logic [rac_pkg::KIND_W-1:0]  kind;
  logic [rac_pkg::REG_W-1:0]   reg_num;
  logic [rac_pkg::ID_W-1:0]    owner_id;
  logic                        last;

  modport source (output valid, output kind, output reg_num, output owner_id, output last,
                  input ready);
  modport sink   (input valid, input kind, input reg_num, input owner_id, input last,
                  output ready);
endinterface

[rtl/rac_ram.sv]
module rac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/rac_dpath.sv]
module rac_dpath #(
  parameter int NUM_REGS = 8,
  parameter int NUM_IDS  = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rac_pkg::rac_cmd_t           cmd,
  output rac_pkg::rac_sts_t           sts,
  input  logic [rac_pkg::MODE_W-1:0]  in_mode,
  input  logic [rac_pkg::ID_W-1:0]    in_var_id,
  input  logic [rac_pkg::REG_W-1:0]   in_reg_sel,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [rac_pkg::KIND_W-1:0]  out_kind,
  output logic [rac_pkg::REG_W-1:0]   out_reg_num,
  output logic [rac_pkg::ID_W-1:0]    out_owner_id,
  output logic                        out_last
);
  import rac_pkg::*;

  localparam int RW = $clog2(NUM_REGS);
  localparam int IW = $clog2(NUM_IDS);
  localparam logic [RW-1:0] VICTIM_RST = RW'(3 % NUM_REGS);
  localparam logic [RW-1:0] REG_MAX    = RW'(NUM_REGS - 1);
  localparam logic [IW-1:0] ID_MAX     = IW'(NUM_IDS - 1);

  // request
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   id_r;
  logic [REG_W-1:0]  rs_r;

  // register file state
  logic [NUM_REGS-1:0] valid_r, valid_nxt;
  logic [ID_W-1:0]     owner_r [NUM_REGS];
  logic [RW-1:0]       victim_r, victim_nxt;
  logic [RW-1:0]       ptr_r, ptr_nxt;

  // lookup results
  logic          hit_r, free_any_r, id_ok_r, rs_ok_r, selv_r;
  logic [RW-1:0] hit_idx_r, free_idx_r;
  logic          hit_c, free_any_c, id_ok_c, rs_ok_c, selv_c;
  logic [RW-1:0] hit_idx_c, free_idx_c;

  // spilled-flag memory and its clearing pass
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_done_r, clr_done_nxt;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [REG_W-1:0]  out_reg_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_last_r;
  logic              out_free;
  logic [ID_W-1:0]   owner_at_ptr;

  assign owner_at_ptr = owner_r[ptr_r];
  assign out_free     = !out_valid_r || out_ready;

  // associative lookup over the register file, lowest index wins
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_any_c = 1'b0;
    free_idx_c = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (valid_r[i] && owner_r[i] == id_r) begin
        hit_c     = 1'b1;
        hit_idx_c = RW'(i);
      end
      if (!valid_r[i]) begin
        free_any_c = 1'b1;
        free_idx_c = RW'(i);
      end
    end
    id_ok_c = int'(id_r) < NUM_IDS;
    rs_ok_c = int'(rs_r) < NUM_REGS;
    selv_c  = rs_ok_c && valid_r[RW'(rs_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= in_mode;
      id_r   <= in_var_id;
      rs_r   <= in_reg_sel;
    end
    if (cmd.look) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      free_any_r <= free_any_c;
      free_idx_r <= free_idx_c;
      id_ok_r    <= id_ok_c;
      rs_ok_r    <= rs_ok_c;
      selv_r     <= selv_c;
    end
    if (cmd.alloc) begin
      owner_r[ptr_r] <= id_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.spill) begin
      valid_nxt[ptr_r] = 1'b0;
    end
    if (cmd.alloc) begin
      valid_nxt[ptr_r] = 1'b1;
    end

    victim_nxt = victim_r;
    if (cmd.vadv) begin
      victim_nxt = (victim_r == REG_MAX) ? '0 : victim_r + 1'b1;
    end

    ptr_nxt = ptr_r;
    if (cmd.ptr_set) begin
      unique case (cmd.ptr_src)
        PS_HIT:    ptr_nxt = hit_idx_r;
        PS_FREE:   ptr_nxt = free_idx_r;
        PS_VICTIM: ptr_nxt = victim_r;
        PS_SEL:    ptr_nxt = RW'(rs_r);
        default:   ptr_nxt = '0;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  // clearing pass, then spill marks
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      clr_cnt_nxt  = clr_cnt_r + 1'b1;
      clr_done_nxt = (clr_cnt_r == ID_MAX);
    end
    ram_we    = !clr_done_r || cmd.spill;
    ram_waddr = clr_done_r ? IW'(owner_at_ptr) : clr_cnt_r;
    ram_wdata = clr_done_r;
  end

  rac_ram #(
    .WIDTH (1),
    .DEPTH (NUM_IDS)
  ) u_spill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (IW'(id_r)),
    .rdata (ram_rdata)
  );

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_last_r <= cmd.emit_last;
      unique case (cmd.emit_reg_src)
        RS_PTR:  out_reg_r <= REG_W'(ptr_r);
        RS_SEL:  out_reg_r <= rs_r;
        default: out_reg_r <= '0;
      endcase
      unique case (cmd.emit_id_src)
        IS_REQ:   out_id_r <= id_r;
        IS_OWNER: out_id_r <= owner_at_ptr;
        default:  out_id_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      victim_r    <= VICTIM_RST;
      ptr_r       <= '0;
      clr_cnt_r   <= '0;
      clr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      victim_r    <= victim_nxt;
      ptr_r       <= ptr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_done_r  <= clr_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_reg_num  = out_reg_r;
  assign out_owner_id = out_id_r;
  assign out_last     = out_last_r;

  assign sts.mode      = mode_r;
  assign sts.id_ok     = id_ok_r;
  assign sts.rs_ok     = rs_ok_r;
  assign sts.hit       = hit_r;
  assign sts.free_any  = free_any_r;
  assign sts.sel_valid = selv_r;
  assign sts.ptr_valid = valid_r[ptr_r];
  assign sts.ptr_last  = (ptr_r == REG_MAX);
  assign sts.spilled   = ram_rdata;
  assign sts.out_free  = out_free;
  assign sts.clr_done  = clr_done_r;

endmodule

[rtl/rac_ctrl.sv]
module rac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rac_pkg::rac_sts_t sts,
  output rac_pkg::rac_cmd_t cmd
);
  import rac_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LOOK   = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_VSPILL = 4'd4;
  localparam logic [3:0] ST_ALLOC  = 4'd5;
  localparam logic [3:0] ST_LOAD   = 4'd6;
  localparam logic [3:0] ST_GRANT  = 4'd7;
  localparam logic [3:0] ST_BIND   = 4'd8;
  localparam logic [3:0] ST_SPILL1 = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;
  localparam logic [3:0] ST_SWEEP  = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (sts.mode)
          MODE_NEED: begin
            if (!sts.id_ok) begin
              if (sts.out_free) begin
                cmd.emit         = 1'b1;
                cmd.emit_kind    = K_REJECT;
                cmd.emit_reg_src = RS_SEL;
                cmd.emit_id_src  = IS_REQ;
                cmd.emit_last    = 1'b1;
                state_nxt        = ST_IDLE;
              end
            end else if (sts.hit) begin
              cmd.ptr_set = 1'b1;
              cmd.ptr_src = PS_HIT;
              state_nxt   = ST_GRANT;
            end else if (sts.free_any) begin
              cmd.ptr_set = 1'b1;
              cmd.ptr_src = PS_FREE;
              state_nxt   = ST_ALLOC;
            end else begin
              cmd.ptr_set = 1'b1;
              cmd.ptr_src = PS_VICTIM;
              state_nxt   = ST_VSPILL;
            end
          end
          MODE_BIND: begin
            if (!sts.id_ok || !sts.rs_ok || sts.hit || sts.sel_valid) begin
              if (sts.out_free) begin
                cmd.emit         = 1'b1;
                cmd.emit_kind    = K_REJECT;
                cmd.emit_reg_src = RS_SEL;
                cmd.emit_id_src  = IS_REQ;
                cmd.emit_last    = 1'b1;
                state_nxt        = ST_IDLE;
              end
            end else begin
              cmd.ptr_set = 1'b1;
              cmd.ptr_src = PS_SEL;
              state_nxt   = ST_BIND;
            end
          end
          MODE_REL1: begin
            if (sts.rs_ok && sts.sel_valid) begin
              cmd.ptr_set = 1'b1;
              cmd.ptr_src = PS_SEL;
              state_nxt   = ST_SPILL1;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            cmd.ptr_set = 1'b1;
            cmd.ptr_src = PS_ZERO;
            state_nxt   = ST_SWEEP;
          end
        endcase
      end
      ST_VSPILL: begin
        if (sts.out_free) begin
          cmd.spill        = 1'b1;
          cmd.vadv         = 1'b1;
          cmd.emit         = 1'b1;
          cmd.emit_kind    = K_STORE;
          cmd.emit_reg_src = RS_PTR;
          cmd.emit_id_src  = IS_OWNER;
          state_nxt        = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = sts.spilled ? ST_LOAD : ST_GRANT;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = K_LOAD;
          cmd.emit_reg_src = RS_PTR;
          cmd.emit_id_src  = IS_REQ;
          state_nxt        = ST_GRANT;
        end
      end
      ST_GRANT: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = K_GRANT;
          cmd.emit_reg_src = RS_PTR;
          cmd.emit_id_src  = IS_REQ;
          cmd.emit_last    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_BIND: begin
        if (sts.out_free) begin
          cmd.alloc        = 1'b1;
          cmd.emit         = 1'b1;
          cmd.emit_kind    = K_DONE;
          cmd.emit_reg_src = RS_SEL;
          cmd.emit_id_src  = IS_REQ;
          cmd.emit_last    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_SPILL1: begin
        if (sts.out_free) begin
          cmd.spill        = 1'b1;
          cmd.emit         = 1'b1;
          cmd.emit_kind    = K_STORE;
          cmd.emit_reg_src = RS_PTR;
          cmd.emit_id_src  = IS_OWNER;
          state_nxt        = ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (sts.ptr_valid) begin
          if (sts.out_free) begin
            cmd.spill        = 1'b1;
            cmd.emit         = 1'b1;
            cmd.emit_kind    = K_STORE;
            cmd.emit_reg_src = RS_PTR;
            cmd.emit_id_src  = IS_OWNER;
            if (sts.ptr_last) begin
              state_nxt = ST_DONE;
            end else begin
              cmd.ptr_inc = 1'b1;
            end
          end
        end else if (sts.ptr_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = K_DONE;
          cmd.emit_reg_src = (sts.mode == MODE_REL1) ? RS_SEL : RS_ZERO;
          cmd.emit_id_src  = IS_ZERO;
          cmd.emit_last    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/register_allocator_with_spill.sv]
// Channel  Dir  Payload                           Handshake
// in_ch    in   mode, var_id, reg_sel             valid/ready, request taken when both high
// out_ch   out  kind, reg_num, owner_id, last     valid/ready, result taken when both high
//
// One request at a time: accept, lookup and decide come in turn (a reject is emitted in the
// decide state), then the results follow, with an allocate step before the grant on a need
// miss; release-all sweeps every register, and a need that spills and reloads emits a store,
// a load and a grant. After reset the spilled-flag memory is cleared one entry a cycle;
// in_ch.ready stays low until that pass is done. A stalled out_ch holds the controller in
// its emit state; a last result waits in the output register as the next request is taken.
module register_allocator_with_spill #(
  parameter int NUM_REGS = 8,
  parameter int NUM_IDS  = 128
) (
  input logic      clk,
  input logic      rst_n,
  rac_in_if.sink   in_ch,
  rac_out_if.source out_ch
);
  import rac_pkg::*;

  rac_cmd_t cmd;
  rac_sts_t sts;

  // sequencer: walks each request through lookup, spill, allocate and result steps
  rac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // register file ownership, victim pointer, spilled flags and the result register
  rac_dpath #(
    .NUM_REGS (NUM_REGS),
    .NUM_IDS  (NUM_IDS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_ch.mode),
    .in_var_id    (in_ch.var_id),
    .in_reg_sel   (in_ch.reg_sel),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_kind     (out_ch.kind),
    .out_reg_num  (out_ch.reg_num),
    .out_owner_id (out_ch.owner_id),
    .out_last     (out_ch.last)
  );

  // a result is only written when the output register is empty or draining
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result written over a pending result");

  // spills only ever act on an occupied register
  a_spill_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.spill |-> sts.ptr_valid)
    else $error("spill of a free register");

  // allocation only ever takes a free register
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !sts.ptr_valid)
    else $error("allocation of an occupied register");

  // no request before the spilled flags are cleared
  a_accept_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> sts.clr_done)
    else $error("request accepted during clearing pass");

endmodule
